[src/nird_pkg.sv]
// ============================================================================
// nird_pkg - shared types and constants for the NEC IR pulse decoder
// Request codes, register indexes, reset windows and the structs passed
// between the decoder's modules.
// ============================================================================
package nird_pkg;

   // request codes
   localparam logic [1:0] REQ_PULSE   = 2'd0;
   localparam logic [1:0] REQ_TIMEOUT = 2'd1;
   localparam logic [1:0] REQ_POP     = 2'd2;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEADER_LOW  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEADER_HIGH = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_LOW  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_HIGH = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW    = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH    = 4'd7;

   // window reset values in microseconds
   localparam logic [15:0] RST_LEADER_LOW  = 16'd4200;
   localparam logic [15:0] RST_LEADER_HIGH = 16'd4700;
   localparam logic [15:0] RST_REPEAT_LOW  = 16'd2000;
   localparam logic [15:0] RST_REPEAT_HIGH = 16'd2500;
   localparam logic [15:0] RST_ZERO_LOW    = 16'd300;
   localparam logic [15:0] RST_ZERO_HIGH   = 16'd800;
   localparam logic [15:0] RST_ONE_LOW     = 16'd1400;
   localparam logic [15:0] RST_ONE_HIGH    = 16'd1800;

   localparam logic [5:0] FRAME_BITS = 6'd32;

   typedef struct packed {
      logic [15:0] lo;
      logic [15:0] hi;
   } window_type;

   typedef struct packed {
      window_type leader;
      window_type rpt;
      window_type zero;
      window_type one;
   } cfg_type;

   // pulse class; at most one bit set, in priority order
   typedef struct packed {
      logic leader;
      logic rpt;
      logic zero;
      logic one;
   } class_type;

   typedef struct packed {
      logic [7:0]  popped_command;
      logic        frame_done;
      logic        frame_valid;
      logic [31:0] frame_word;
      logic [7:0]  held_command;
      logic        in_frame;
   } rsp_type;

   // exclusive window test
   function automatic logic in_window(logic [15:0] w, window_type win);
      return (w > win.lo) && (w < win.hi);
   endfunction

endpackage

[src/nird_csr.sv]
// ============================================================================
// nird_csr - pulse window registers
// Eight 16-bit exclusive bounds, written through the csr port.
// ============================================================================
module nird_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [nird_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_data,
   output nird_pkg::cfg_type               cfg
);

   nird_pkg::cfg_type cfg_ff;
   nird_pkg::cfg_type cfg_in;

   // decode the register index; other indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            nird_pkg::CSR_LEADER_LOW:  cfg_in.leader.lo = csr_data;
            nird_pkg::CSR_LEADER_HIGH: cfg_in.leader.hi = csr_data;
            nird_pkg::CSR_REPEAT_LOW:  cfg_in.rpt.lo    = csr_data;
            nird_pkg::CSR_REPEAT_HIGH: cfg_in.rpt.hi    = csr_data;
            nird_pkg::CSR_ZERO_LOW:    cfg_in.zero.lo   = csr_data;
            nird_pkg::CSR_ZERO_HIGH:   cfg_in.zero.hi   = csr_data;
            nird_pkg::CSR_ONE_LOW:     cfg_in.one.lo    = csr_data;
            nird_pkg::CSR_ONE_HIGH:    cfg_in.one.hi    = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader.lo <= nird_pkg::RST_LEADER_LOW;
         cfg_ff.leader.hi <= nird_pkg::RST_LEADER_HIGH;
         cfg_ff.rpt.lo    <= nird_pkg::RST_REPEAT_LOW;
         cfg_ff.rpt.hi    <= nird_pkg::RST_REPEAT_HIGH;
         cfg_ff.zero.lo   <= nird_pkg::RST_ZERO_LOW;
         cfg_ff.zero.hi   <= nird_pkg::RST_ZERO_HIGH;
         cfg_ff.one.lo    <= nird_pkg::RST_ONE_LOW;
         cfg_ff.one.hi    <= nird_pkg::RST_ONE_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/nird_classify.sv]
// ============================================================================
// nird_classify - pulse width classifier
// Tests a width against the leader, repeat, zero and one windows; the
// first window that matches wins.
// ============================================================================
module nird_classify (
   input  logic [15:0]          pulse_us,
   input  nird_pkg::cfg_type    cfg,
   output nird_pkg::class_type  cls
);

   logic hit_leader;
   logic hit_rpt;
   logic hit_zero;
   logic hit_one;

   assign hit_leader = nird_pkg::in_window(pulse_us, cfg.leader);
   assign hit_rpt    = nird_pkg::in_window(pulse_us, cfg.rpt);
   assign hit_zero   = nird_pkg::in_window(pulse_us, cfg.zero);
   assign hit_one    = nird_pkg::in_window(pulse_us, cfg.one);

   // resolve overlaps by priority
   assign cls.leader = hit_leader;
   assign cls.rpt    = !hit_leader && hit_rpt;
   assign cls.zero   = !hit_leader && !hit_rpt && hit_zero;
   assign cls.one    = !hit_leader && !hit_rpt && !hit_zero && hit_one;

endmodule

[src/nird_core.sv]
// ============================================================================
// nird_core - frame assembly and command state
// Holds the frame shifter, bit count, stored frame and commands; works out
// the next state and the result of one request.
// ============================================================================
module nird_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [1:0]           req_type,
   input  nird_pkg::class_type  cls,
   output nird_pkg::rsp_type    rsp
);

   logic        receiving_ff, receiving_in;
   logic [5:0]  bit_index_ff, bit_index_in;
   logic [31:0] shift_word_ff, shift_word_in;
   logic [31:0] stored_frame_ff, stored_frame_in;
   logic [7:0]  verified_ff, verified_in;
   logic [7:0]  posted_ff, posted_in;

   logic [31:0] shift_set;
   logic [5:0]  bit_next;
   logic        check_ok;

   // shift in the next bit, LSB first
   assign shift_set = cls.one ? (shift_word_ff | (32'd1 << bit_index_ff[4:0]))
                              : shift_word_ff;
   assign bit_next  = bit_index_ff + 6'd1;
   assign check_ok  = (shift_set[7:0] == ~shift_set[15:8]) &&
                      (shift_set[23:16] == ~shift_set[31:24]);

   // next state and result
   always_comb begin
      receiving_in    = receiving_ff;
      bit_index_in    = bit_index_ff;
      shift_word_in   = shift_word_ff;
      stored_frame_in = stored_frame_ff;
      verified_in     = verified_ff;
      posted_in       = posted_ff;
      rsp.popped_command = 8'd0;
      rsp.frame_done     = 1'b0;
      rsp.frame_valid    = 1'b0;
      case (req_type)
         nird_pkg::REQ_PULSE: begin
            if (cls.leader) begin
               receiving_in  = 1'b1;
               bit_index_in  = 6'd0;
               shift_word_in = 32'd0;
            end else if (cls.rpt) begin
               if (!receiving_ff && (verified_ff != 8'd0)) begin
                  posted_in = verified_ff;
               end
            end else if (receiving_ff) begin
               if (!cls.zero && !cls.one) begin
                  receiving_in  = 1'b0;
                  bit_index_in  = 6'd0;
                  shift_word_in = 32'd0;
               end else begin
                  shift_word_in = shift_set;
                  bit_index_in  = bit_next;
                  if (bit_next >= nird_pkg::FRAME_BITS) begin
                     stored_frame_in = shift_set;
                     receiving_in    = 1'b0;
                     rsp.frame_done  = 1'b1;
                     if (check_ok) begin
                        rsp.frame_valid = 1'b1;
                        verified_in     = shift_set[23:16];
                        posted_in       = shift_set[23:16];
                     end
                  end
               end
            end
         end
         nird_pkg::REQ_TIMEOUT: begin
            receiving_in  = 1'b0;
            bit_index_in  = 6'd0;
            shift_word_in = 32'd0;
         end
         nird_pkg::REQ_POP: begin
            rsp.popped_command = posted_ff;
            posted_in          = 8'd0;
         end
         default: begin
         end
      endcase
      rsp.frame_word   = stored_frame_in;
      rsp.held_command = verified_in;
      rsp.in_frame     = receiving_in;
   end

   // commit state when the request moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff    <= 1'b0;
         bit_index_ff    <= 6'd0;
         shift_word_ff   <= 32'd0;
         stored_frame_ff <= 32'd0;
         verified_ff     <= 8'd0;
         posted_ff       <= 8'd0;
      end else if (fire) begin
         receiving_ff    <= receiving_in;
         bit_index_ff    <= bit_index_in;
         shift_word_ff   <= shift_word_in;
         stored_frame_ff <= stored_frame_in;
         verified_ff     <= verified_in;
         posted_ff       <= posted_in;
      end
   end

endmodule

[src/nec_ir_pulse_decoder.sv]
// ============================================================================
// nec_ir_pulse_decoder - NEC infrared remote pulse decoder
// Classifies measured pulse widths, assembles 32-bit frames, checks the
// inverse bytes and posts verified commands for pop requests.
// ============================================================================
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_pulse_us
//   rsp      out        rsp_valid/rsp_stall  popped_command .. in_frame
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One request per cycle sustained while rsp_stall is low; one result per request.
// A request is held in the input register, decoded against the window
// compares and the frame state, and the result is loaded into the output
// register when the request advances. With both registers full, rsp_stall reaches
// req_stall combinationally in the same cycle.
// Synchronous reset restores the window defaults and clears frame state.
// csr_ready is always high; write only while idle.
// ============================================================================
module nec_ir_pulse_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [15:0]                      req_pulse_us,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_popped_command,
   output logic                             rsp_frame_done,
   output logic                             rsp_frame_valid,
   output logic [31:0]                      rsp_frame_word,
   output logic [7:0]                       rsp_held_command,
   output logic                             rsp_in_frame,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nird_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_data
);

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_type_ff;
   logic [15:0]       in_pulse_ff;
   logic              out_valid_ff, out_valid_in;
   nird_pkg::rsp_type out_ff;

   logic                accept;
   logic                advance;
   nird_pkg::cfg_type   cfg;
   nird_pkg::class_type cls;
   nird_pkg::rsp_type   result;

   // handshake
   assign csr_ready    = 1'b1;
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   nird_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   nird_classify u_classify (
      .pulse_us (in_pulse_ff),
      .cfg      (cfg),
      .cls      (cls)
   );

   nird_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .req_type (in_type_ff),
      .cls      (cls),
      .rsp      (result)
   );

   // input register: load on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_type_ff  <= req_type;
         in_pulse_ff <= req_pulse_us;
      end
   end

   // result register: load when the request advances
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_popped_command = out_ff.popped_command;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_frame_valid    = out_ff.frame_valid;
   assign rsp_frame_word     = out_ff.frame_word;
   assign rsp_held_command   = out_ff.held_command;
   assign rsp_in_frame       = out_ff.in_frame;

   // a passing frame is always a completed one
   a_valid_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid |-> rsp_frame_done)
      else $error("frame_valid without frame_done");

   // a completed frame ends reception
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_in_frame)
      else $error("frame_done while still in frame");

   // a verified frame latches its command byte
   a_held_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid |-> rsp_held_command == rsp_frame_word[23:16])
      else $error("held command differs from verified frame");

   // an accepted request occupies the input register next cycle
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted request lost");

   // an advancing request shows up as a result
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced request produced no result");

endmodule
